// ===== rtl/core/opp_pkg.sv =====
// ----------------------------------------------------------------------------
// opp_pkg
// Shared word types, sizes and fixed point helpers for the predistorter.
// ----------------------------------------------------------------------------
`default_nettype none

package opp_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_WIDTH = 32;
	localparam int DATA_W     = 32;
	localparam int NUM_REGS   = 6;
	localparam int ADDR_W     = 5;
	localparam int IDX_W      = 3;

	typedef logic signed [WORD_WIDTH-1:0]   word_t;
	typedef logic signed [2*WORD_WIDTH-1:0] prod_t;
	typedef logic signed [DATA_W-1:0]       data_t;
	typedef logic [IDX_W-1:0]               reg_idx_t;

	localparam reg_idx_t REG_GAIN1_REAL = 3'd0;
	localparam reg_idx_t REG_GAIN1_IMAG = 3'd1;
	localparam reg_idx_t REG_GAIN3_REAL = 3'd2;
	localparam reg_idx_t REG_GAIN3_IMAG = 3'd3;
	localparam reg_idx_t REG_GAIN5_REAL = 3'd4;
	localparam reg_idx_t REG_GAIN5_IMAG = 3'd5;

	typedef struct packed {
		word_t gain1_real;
		word_t gain1_imag;
		word_t gain3_real;
		word_t gain3_imag;
		word_t gain5_real;
		word_t gain5_imag;
	} gains_t;

	function automatic word_t to_word(data_t v);
		return v[WORD_WIDTH-1:0];
	endfunction

	function automatic word_t wmul(word_t a, word_t b);
		prod_t p;
		p = prod_t'(a) * prod_t'(b);
		p = p >>> FRAC_BITS;
		return p[WORD_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/opp_sample_if.sv =====
// ----------------------------------------------------------------------------
// opp_sample_if
// Input channel: one complex sample word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface opp_sample_if;
	logic                   valid;
	logic                   ready;
	logic [opp_pkg::DATA_W-1:0] sample_real;
	logic [opp_pkg::DATA_W-1:0] sample_imag;

	modport source (output valid, output sample_real, output sample_imag, input ready);
	modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/opp_result_if.sv =====
// ----------------------------------------------------------------------------
// opp_result_if
// Output channel: one complex result word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface opp_result_if;
	logic                   valid;
	logic                   ready;
	logic [opp_pkg::DATA_W-1:0] result_real;
	logic [opp_pkg::DATA_W-1:0] result_imag;

	modport source (output valid, output result_real, output result_imag, input ready);
	modport sink   (input valid, input result_real, input result_imag, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/odd_order_polynomial_predistorter.sv =====
// ----------------------------------------------------------------------------
// odd_order_polynomial_predistorter
// Memoryless fifth-order predistorter: Y = (g1 + g3*|X|^2 + g5*|X|^4) * X.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  din      in         valid / ready    sample_real, sample_imag
//  dout     out        valid / ready    result_real, result_imag
//  apb      in/out     psel / penable   paddr, pwdata, prdata (6 gain words)
//
//  Takes one sample per clock while din is ready; each sample passes the
//  eight register stages: an input register, then the multiply and add chain.
//  arst_n clears all stage valid bits and the gains to zero.
//  A stall on dout holds the words in place; empty stages keep filling, so
//  din stays ready until every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_order_polynomial_predistorter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	opp_sample_if.sink                      din,
	opp_result_if.source                    dout,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [opp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [opp_pkg::DATA_W-1:0] pwdata,
	output logic      [opp_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import opp_pkg::*;

	gains_t gains;

	opp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	opp_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.gains  (gains),
		.din    (din),
		.dout   (dout)
	);

endmodule

`default_nettype wire

// ===== rtl/core/opp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// opp_cfg_regs
// APB register file holding the complex gains of the polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module opp_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [opp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [opp_pkg::DATA_W-1:0] pwdata,
	output logic      [opp_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output opp_pkg::gains_t                 gains
);
	import opp_pkg::*;

	gains_t   gains_q;
	reg_idx_t idx;
	logic     wr_en;
	word_t    wword;
	word_t    rword;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign wword  = to_word(pwdata);
	assign gains  = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN1_REAL: gains_q.gain1_real <= wword;
				REG_GAIN1_IMAG: gains_q.gain1_imag <= wword;
				REG_GAIN3_REAL: gains_q.gain3_real <= wword;
				REG_GAIN3_IMAG: gains_q.gain3_imag <= wword;
				REG_GAIN5_REAL: gains_q.gain5_real <= wword;
				REG_GAIN5_IMAG: gains_q.gain5_imag <= wword;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN1_REAL: rword = gains_q.gain1_real;
			REG_GAIN1_IMAG: rword = gains_q.gain1_imag;
			REG_GAIN3_REAL: rword = gains_q.gain3_real;
			REG_GAIN3_IMAG: rword = gains_q.gain3_imag;
			REG_GAIN5_REAL: rword = gains_q.gain5_real;
			REG_GAIN5_IMAG: rword = gains_q.gain5_imag;
			default:        rword = '0;
		endcase
		prdata = DATA_W'(rword);
	end

endmodule

`default_nettype wire

// ===== rtl/core/opp_pipe.sv =====
// ----------------------------------------------------------------------------
// opp_pipe
// Eight-stage datapath: input register, |X|^2, |X|^4, complex gain sum and
// final complex product, at most one multiply or one add level per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module opp_pipe (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire opp_pkg::gains_t gains,
	opp_sample_if.sink           din,
	opp_result_if.source         dout
);
	import opp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	word_t xr_s1, xi_s1;
	word_t xr_s2, xi_s2, prr_s2, pii_s2;
	word_t xr_s3, xi_s3, m2_s3;
	word_t xr_s4, xi_s4, m4_s4, t3r_s4, t3i_s4;
	word_t xr_s5, xi_s5, u5r_s5, u5i_s5, sr_s5, si_s5;
	word_t xr_s6, xi_s6, cr_s6, ci_s6;
	word_t rr_s7, ii_s7, ri_s7, ir_s7;
	word_t yr_s8, yi_s8;

	// advance a stage when it is empty or its successor advances
	assign en8 = ~v_s8 | dout.ready;
	assign en7 = ~v_s7 | en8;
	assign en6 = ~v_s6 | en7;
	assign en5 = ~v_s5 | en6;
	assign en4 = ~v_s4 | en5;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign din.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= din.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && din.valid) begin
			xr_s1 <= to_word(din.sample_real);
			xi_s1 <= to_word(din.sample_imag);
		end
		if (en2 && v_s1) begin
			xr_s2  <= xr_s1;
			xi_s2  <= xi_s1;
			prr_s2 <= wmul(xr_s1, xr_s1);
			pii_s2 <= wmul(xi_s1, xi_s1);
		end
		if (en3 && v_s2) begin
			xr_s3 <= xr_s2;
			xi_s3 <= xi_s2;
			m2_s3 <= prr_s2 + pii_s2;
		end
		if (en4 && v_s3) begin
			xr_s4  <= xr_s3;
			xi_s4  <= xi_s3;
			m4_s4  <= wmul(m2_s3, m2_s3);
			t3r_s4 <= wmul(m2_s3, gains.gain3_real);
			t3i_s4 <= wmul(m2_s3, gains.gain3_imag);
		end
		if (en5 && v_s4) begin
			xr_s5  <= xr_s4;
			xi_s5  <= xi_s4;
			u5r_s5 <= wmul(m4_s4, gains.gain5_real);
			u5i_s5 <= wmul(m4_s4, gains.gain5_imag);
			sr_s5  <= t3r_s4 + gains.gain1_real;
			si_s5  <= t3i_s4 + gains.gain1_imag;
		end
		if (en6 && v_s5) begin
			xr_s6 <= xr_s5;
			xi_s6 <= xi_s5;
			cr_s6 <= u5r_s5 + sr_s5;
			ci_s6 <= u5i_s5 + si_s5;
		end
		if (en7 && v_s6) begin
			rr_s7 <= wmul(cr_s6, xr_s6);
			ii_s7 <= wmul(ci_s6, xi_s6);
			ri_s7 <= wmul(cr_s6, xi_s6);
			ir_s7 <= wmul(ci_s6, xr_s6);
		end
		if (en8 && v_s7) begin
			yr_s8 <= rr_s7 - ii_s7;
			yi_s8 <= ri_s7 + ir_s7;
		end
	end

	assign dout.valid       = v_s8;
	assign dout.result_real = DATA_W'(yr_s8);
	assign dout.result_imag = DATA_W'(yi_s8);

endmodule

`default_nettype wire
